/* sv/region_dominant_color_classifier_macros.svh */
// ----------------------------------------------------------------------------
// region dominant color classifier assertion macros
// shared concurrent assertion wrappers, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef REGION_DOMINANT_COLOR_CLASSIFIER_MACROS_SVH
`define REGION_DOMINANT_COLOR_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define RDCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdcc same-cycle check failed");

// next-cycle implication
`define RDCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdcc next-cycle check failed");

`endif

/* sv/rdcc_pkg.sv */
// ----------------------------------------------------------------------------
// rdcc_pkg
// widths, register indexes, reset values and codes of the color classifier
// ----------------------------------------------------------------------------
package rdcc_pkg;

  // field widths
  localparam int CHAN_BITS   = 8;
  localparam int COL_BITS    = 12;
  localparam int TW_BITS     = 11;
  localparam int RS_BITS     = 12;
  localparam int TOTAL_BITS  = 24;
  localparam int BAND_BITS   = 2;
  localparam int CODE_BITS   = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 80;
  localparam int NUM_BANDS   = 3;
  localparam int NUM_COLORS  = 3;

  // parameter defaults
  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_COUNT_BITS  = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_THIRD_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_START = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRONG_MIN  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEAK_MAX    = 2'd3;

  // register reset values
  localparam logic [TW_BITS-1:0]   RST_THIRD_WIDTH = 11'd213;
  localparam logic [RS_BITS-1:0]   RST_RIGHT_START = 12'd426;
  localparam logic [CHAN_BITS-1:0] RST_STRONG_MIN  = 8'd200;
  localparam logic [CHAN_BITS-1:0] RST_WEAK_MAX    = 8'd50;

  // color slots inside a band
  localparam int CLR_RED   = 0;
  localparam int CLR_GREEN = 1;
  localparam int CLR_BLUE  = 2;

  // band indexes
  localparam logic [BAND_BITS-1:0] BAND_LEFT   = 2'd0;
  localparam logic [BAND_BITS-1:0] BAND_CENTER = 2'd1;
  localparam logic [BAND_BITS-1:0] BAND_RIGHT  = 2'd2;

  // dominant color codes
  localparam logic [CODE_BITS-1:0] CODE_OTHER = 2'd1;
  localparam logic [CODE_BITS-1:0] CODE_GREEN = 2'd2;
  localparam logic [CODE_BITS-1:0] CODE_RED   = 2'd3;

  // one registered pixel
  typedef struct packed {
    logic [CHAN_BITS-1:0] blue;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] red;
    logic [COL_BITS-1:0]  column;
    logic                 frame_end;
  } pixel_t;

endpackage

/* sv/region_dominant_color_classifier.sv */
// ----------------------------------------------------------------------------
// region_dominant_color_classifier
// counts strong red, green and blue pixels in three column bands of a frame
// and reports the dominant color of each band at frame end
// ----------------------------------------------------------------------------
// counting: a pixel is counted when it leaves the input register; the three band
//   results of a frame enter the snapshot together with the count of its last pixel
// throughput: one pixel per cycle; a frame end holds its pixel in the input
//   register until the three results of the previous frame have drained
// reset: counters cleared, registers back to their defaults, no item pending
// ----------------------------------------------------------------------------
`include "region_dominant_color_classifier_macros.svh"

module region_dominant_color_classifier #(
  parameter int MAX_COLUMNS = rdcc_pkg::DEF_MAX_COLUMNS,
  parameter int COUNT_BITS  = rdcc_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [rdcc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rdcc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  // pixel stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // blue[7:0], green[15:8], red[23:16], column[35:24], zero fill[39:36]
  input  logic [rdcc_pkg::IN_DATA_BITS-1:0]   in_tdata,
  input  logic                                in_tlast,   // frame_end
  // band result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // band[1:0], color_code[3:2], red_total[27:4], green_total[51:28],
  // blue_total[75:52], zero fill[79:76]
  output logic [rdcc_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic                                out_tlast   // last_band
);
  import rdcc_pkg::*;

  localparam int SPAN_BITS = COL_BITS + 1;

  typedef logic [COUNT_BITS-1:0] count_t;

  // configuration registers
  logic [TW_BITS-1:0]   third_width_r;
  logic [RS_BITS-1:0]   right_start_r;
  logic [CHAN_BITS-1:0] strong_min_r;
  logic [CHAN_BITS-1:0] weak_max_r;

  // input stage
  pixel_t s1_pix_r;
  logic   s1_valid_r;
  logic   s1_adv;
  logic   s1_close;

  // counters and frame snapshot
  count_t cnt_r    [NUM_BANDS][NUM_COLORS];
  count_t cnt_nxt  [NUM_BANDS][NUM_COLORS];
  count_t snap_r   [NUM_BANDS][NUM_COLORS];
  logic                 snap_valid_r;
  logic [BAND_BITS-1:0] snap_idx_r;
  logic                 snap_free;
  logic                 out_done;

  logic [NUM_BANDS-1:0]  band_hit;
  logic [NUM_COLORS-1:0] color_hit;
  logic [SPAN_BITS-1:0]  col_w;
  logic [SPAN_BITS-1:0]  start_w [NUM_BANDS];

  count_t               rc, gc, bc;
  logic [CODE_BITS-1:0] code;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      third_width_r <= RST_THIRD_WIDTH;
      right_start_r <= RST_RIGHT_START;
      strong_min_r  <= RST_STRONG_MIN;
      weak_max_r    <= RST_WEAK_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THIRD_WIDTH: third_width_r <= cfg_wdata[TW_BITS-1:0];
        REG_RIGHT_START: right_start_r <= cfg_wdata[RS_BITS-1:0];
        REG_STRONG_MIN:  strong_min_r  <= cfg_wdata[CHAN_BITS-1:0];
        REG_WEAK_MAX:    weak_max_r    <= cfg_wdata[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake: a frame end waits for room in the snapshot
  assign out_done  = out_tvalid && out_tready && (snap_idx_r == BAND_RIGHT);
  assign snap_free = !snap_valid_r || out_done;
  assign s1_adv    = s1_valid_r && (!s1_pix_r.frame_end || snap_free);
  assign s1_close  = s1_adv && s1_pix_r.frame_end;
  assign in_tready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pix_r.blue      <= in_tdata[7:0];
      s1_pix_r.green     <= in_tdata[15:8];
      s1_pix_r.red       <= in_tdata[23:16];
      s1_pix_r.column    <= in_tdata[35:24];
      s1_pix_r.frame_end <= in_tlast;
    end
  end

  // band membership, each band tested on its own
  assign col_w      = SPAN_BITS'(s1_pix_r.column);
  assign start_w[0] = '0;
  assign start_w[1] = SPAN_BITS'(third_width_r);
  assign start_w[2] = SPAN_BITS'(right_start_r);

  always_comb begin
    for (int k = 0; k < NUM_BANDS; k++) begin
      band_hit[k] = (col_w >= start_w[k]) &&
                    (col_w < start_w[k] + SPAN_BITS'(third_width_r)) &&
                    (32'(s1_pix_r.column) < MAX_COLUMNS);
    end
  end

  // color tests, each color on its own
  always_comb begin
    color_hit[CLR_RED]   = (s1_pix_r.red >= strong_min_r) &&
                           (s1_pix_r.green <= weak_max_r) &&
                           (s1_pix_r.blue <= weak_max_r);
    color_hit[CLR_GREEN] = (s1_pix_r.green >= strong_min_r) &&
                           (s1_pix_r.red <= weak_max_r) &&
                           (s1_pix_r.blue <= weak_max_r);
    color_hit[CLR_BLUE]  = (s1_pix_r.blue >= strong_min_r) &&
                           (s1_pix_r.red <= weak_max_r) &&
                           (s1_pix_r.green <= weak_max_r);
  end

  // saturating counter update
  always_comb begin
    for (int k = 0; k < NUM_BANDS; k++) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        if (s1_adv && band_hit[k] && color_hit[c] && (cnt_r[k][c] != '1)) begin
          cnt_nxt[k][c] = cnt_r[k][c] + count_t'(1);
        end else begin
          cnt_nxt[k][c] = cnt_r[k][c];
        end
      end
    end
  end

  // counters cleared once the frame end pixel leaves the input register
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_BANDS; k++) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        if (!rst_n || s1_close) begin
          cnt_r[k][c] <= '0;
        end else begin
          cnt_r[k][c] <= cnt_nxt[k][c];
        end
      end
    end
  end

  // frame snapshot takes the counts including the frame end pixel
  always_ff @(posedge clk) begin
    if (s1_close) begin
      snap_r <= cnt_nxt;
    end
  end

  // result sequencing over the three bands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      snap_idx_r   <= BAND_LEFT;
    end else if (s1_close) begin
      snap_valid_r <= 1'b1;
      snap_idx_r   <= BAND_LEFT;
    end else if (out_tvalid && out_tready) begin
      if (snap_idx_r == BAND_RIGHT) begin
        snap_valid_r <= 1'b0;
      end else begin
        snap_idx_r <= snap_idx_r + BAND_BITS'(1);
      end
    end
  end

  // dominant color of the band on the output
  assign rc = snap_r[snap_idx_r][CLR_RED];
  assign gc = snap_r[snap_idx_r][CLR_GREEN];
  assign bc = snap_r[snap_idx_r][CLR_BLUE];

  always_comb begin
    priority if ((rc > gc) && (rc > bc)) begin
      code = CODE_RED;
    end else if ((gc > rc) && (gc > bc)) begin
      code = CODE_GREEN;
    end else begin
      code = CODE_OTHER;
    end
  end

  // result packing
  assign out_tvalid = snap_valid_r;
  assign out_tlast  = (snap_idx_r == BAND_RIGHT);
  assign out_tdata  = {4'b0000, TOTAL_BITS'(bc), TOTAL_BITS'(gc), TOTAL_BITS'(rc),
                       code, snap_idx_r};

  // checks
  `RDCC_ASSERT_NOW(a_close_has_room, s1_close, snap_free)
  `RDCC_ASSERT_NEXT(a_close_starts_left, s1_close,
                    snap_valid_r && (snap_idx_r == BAND_LEFT))
  `RDCC_ASSERT_NEXT(a_drain_empties, out_done && !s1_close, !snap_valid_r)
  `RDCC_ASSERT_NOW(a_idx_in_range, out_tvalid,
                   (snap_idx_r == BAND_LEFT) || (snap_idx_r == BAND_CENTER) ||
                   (snap_idx_r == BAND_RIGHT))

endmodule
